FILE: hw/rtl/max_subarray_segment_tree_defines.svh
// Assertion macros for the max-subarray segment tree block.
// Used by the RTL files that carry concurrent assertions.
`ifndef MAX_SUBARRAY_SEGMENT_TREE_DEFINES_SVH
`define MAX_SUBARRAY_SEGMENT_TREE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/msst_pkg.sv
// Package for the max-subarray segment tree: node type, widths and combine function.
// No dependencies.
package msst_pkg;
    localparam int unsigned LEAVES_DEF = 1024;
    localparam int unsigned POS_W = 10;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned TOT_W = 42;
    localparam int unsigned MAX_W = 41;

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic signed [TOT_W-1:0] total;
        logic [MAX_W-1:0] prefix;
        logic [MAX_W-1:0] suffix;
        logic [MAX_W-1:0] best;
    } t_node;

    localparam int unsigned NODE_W = $bits(t_node);

    // Maximum of two signed figures, both at the sum width.
    function automatic logic signed [TOT_W-1:0] smax(
        input logic signed [TOT_W-1:0] a,
        input logic signed [TOT_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // Join adjacent spans a then b.
    function automatic t_node join_node(input t_node a, input t_node b);
        t_node r;
        logic signed [TOT_W-1:0] ap, as, ab, bp, bs, bb;
        ap = $signed({1'b0, a.prefix});
        as = $signed({1'b0, a.suffix});
        ab = $signed({1'b0, a.best});
        bp = $signed({1'b0, b.prefix});
        bs = $signed({1'b0, b.suffix});
        bb = $signed({1'b0, b.best});
        r.total = a.total + b.total;
        r.prefix = MAX_W'(smax(ap, a.total + bp));
        r.suffix = MAX_W'(smax(bs, b.total + as));
        r.best = MAX_W'(smax(smax(ab, bb), as + bp));
        return r;
    endfunction
endpackage

FILE: hw/rtl/msst_node_ram.sv
// Node store of the segment tree: one synchronous memory with a registered read port.
// Depends on msst_pkg.
module msst_node_ram #(
    parameter int unsigned ADDR_W = 11
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  msst_pkg::t_node       i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr,
    output msst_pkg::t_node       o_rdata
);
    msst_pkg::t_node r_mem [2**ADDR_W];
    msst_pkg::t_node r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/max_subarray_segment_tree.sv
// Top level of the max-subarray segment tree: control sequencer and stream ports.
// Depends on msst_pkg, msst_node_ram and max_subarray_segment_tree_defines.svh.
//
// A clearing pass runs after reset, one node per cycle over all 2*P nodes (P the leaf count rounded
// up to a power of two; 2048 nodes at the default), while no item is accepted. A write updates
// the path from its leaf up to the root (a write outside the array changes no node), and a query
// visits at most 2*log2(P) tree nodes, one after another, since the
// single read port of the node memory is read once per node of the walk; an empty range walks
// no node. One item is worked at a time; a new item is taken as soon as the sequencer is idle,
// even while the previous result still waits in the output register. A finished item waits
// until that register is free.
`include "max_subarray_segment_tree_defines.svh"
module max_subarray_segment_tree #(
    parameter int unsigned LEAVES = msst_pkg::LEAVES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind is tuser.
    input  logic         s_axis_tuser,
    // tdata: position[9:0], value[41:10], query_left[51:42], query_right[61:52], zeros.
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: best_subarray[40:0], total_sum[82:41], best_prefix[123:83],
    // best_suffix[164:124], zeros.
    output logic [167:0] m_axis_tdata
);
    localparam int unsigned LVL = (LEAVES <= 1) ? 0 : $clog2(LEAVES);
    localparam int unsigned P = 1 << LVL;
    localparam int unsigned AW = LVL + 1;
    localparam int unsigned PW = msst_pkg::POS_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WLEAF, S_WRD0, S_WJOIN,
        S_QSTEP, S_QWAIT, S_ROOT, S_ROOTW, S_OUT
    } t_state;

    t_state r_state;
    logic [AW:0] r_clr;
    logic [AW-1:0] r_k;
    logic [AW:0] r_lo, r_hi;
    logic r_qside;  // 1 = reading for left accumulator, 0 = for right
    logic signed [msst_pkg::VAL_W-1:0] r_val;
    msst_pkg::t_node r_left, r_right, r_sib, r_res;
    logic r_ovalid;

    logic we;
    logic [AW-1:0] waddr, raddr;
    msst_pkg::t_node wdata, rdata, zero_n, leaf_n;
    logic out_free, out_load;

    msst_node_ram #(.ADDR_W(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign zero_n = '0;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {3'b0, r_res.suffix, r_res.prefix, r_res.total, r_res.best};

    // The result register can take a new result when empty or emptied at this edge.
    assign out_free = !r_ovalid || m_axis_tready;
    assign out_load = out_free &&
                      ((r_state == S_QSTEP && !(r_lo < r_hi)) || r_state == S_ROOTW);

    // Leaf figures from the stored value.
    always_comb begin
        leaf_n.total = msst_pkg::TOT_W'(r_val);
        leaf_n.prefix = r_val[msst_pkg::VAL_W-1] ? '0 : msst_pkg::MAX_W'(r_val);
        leaf_n.suffix = leaf_n.prefix;
        leaf_n.best = leaf_n.prefix;
    end

    // Memory port control.
    always_comb begin
        we = 1'b0;
        waddr = r_k;
        wdata = zero_n;
        raddr = r_k;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                waddr = r_clr[AW-1:0];
            end
            S_WLEAF: begin
                we = 1'b1;
                wdata = leaf_n;
                raddr = r_k ^ AW'(1);
            end
            S_WRD0: raddr = r_k;
            S_WJOIN: begin
                we = 1'b1;
                waddr = r_k >> 1;
                wdata = r_k[0] ? msst_pkg::join_node(r_sib, rdata)
                               : msst_pkg::join_node(rdata, r_sib);
                raddr = (r_k >> 1) ^ AW'(1);
            end
            S_QSTEP: raddr = r_lo[0] ? AW'(r_lo) : AW'(r_hi - (AW+1)'(1));
            S_ROOT: raddr = AW'(1);
            S_ROOTW: raddr = AW'(1);
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(2*P-1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_val <= s_axis_tdata[PW+31:PW];
                    r_left <= '0;
                    r_right <= '0;
                    if (s_axis_tuser == msst_pkg::KIND_WRITE) begin
                        r_k <= AW'(P) + AW'(s_axis_tdata[PW-1:0]);
                        if (32'(s_axis_tdata[PW-1:0]) < LEAVES && LVL > 0) r_state <= S_WLEAF;
                        else if (32'(s_axis_tdata[PW-1:0]) < LEAVES) r_state <= S_WLEAF;
                        else r_state <= S_ROOT;
                    end else begin
                        logic [PW-1:0] lo, hi;
                        lo = s_axis_tdata[PW+41:PW+32];
                        hi = s_axis_tdata[2*PW+41:PW+42];
                        if (32'(hi) > LEAVES - 1) hi = PW'(LEAVES - 1);
                        // An empty range walks no node and yields the zero node.
                        if (lo > hi) begin
                            r_lo <= '0;
                            r_hi <= '0;
                        end else begin
                            r_lo <= (AW+1)'(P) + (AW+1)'(lo);
                            r_hi <= (AW+1)'(P) + (AW+1)'(hi) + (AW+1)'(1);
                        end
                        r_state <= S_QSTEP;
                    end
                end
                S_WLEAF: r_state <= (LVL == 0) ? S_ROOT : S_WRD0;
                // rdata holds the sibling read in the previous cycle.
                S_WRD0: begin
                    r_sib <= rdata;
                    r_state <= S_WJOIN;
                end
                // rdata holds the freshly written child (read in the cycle after its write).
                S_WJOIN: begin
                    r_k <= r_k >> 1;
                    r_state <= ((r_k >> 1) == AW'(1)) ? S_ROOT : S_WRD0;
                end
                S_QSTEP: begin
                    if (!(r_lo < r_hi)) begin
                        if (out_free) begin
                            r_res <= msst_pkg::join_node(r_left, r_right);
                            r_state <= S_IDLE;
                        end
                    end else if (!r_lo[0] && !r_hi[0]) begin
                        r_lo <= r_lo >> 1;
                        r_hi <= r_hi >> 1;
                    end else begin
                        r_qside <= r_lo[0];
                        r_state <= S_QWAIT;
                    end
                end
                S_QWAIT: begin
                    if (r_qside) begin
                        r_left <= msst_pkg::join_node(r_left, rdata);
                        r_lo <= r_lo + (AW+1)'(1);
                    end else begin
                        r_right <= msst_pkg::join_node(rdata, r_right);
                        r_hi <= r_hi - (AW+1)'(1);
                    end
                    r_state <= S_QSTEP;
                end
                S_ROOT: r_state <= S_ROOTW;
                S_ROOTW: begin
                    if (out_free) begin
                        r_res <= rdata;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MSST_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !s_axis_tready)
    `MSST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `MSST_ASSERT_NXT(a_root_gives_out, i_clk, i_rst_n, r_state == S_ROOTW, m_axis_tvalid)
    `MSST_ASSERT_IMP(a_query_bounds, i_clk, i_rst_n, r_state == S_QWAIT, r_lo < r_hi)
endmodule
